// ===== design/window_latency_stats_assert.svh =====
// ----------------------------------------------------------------------------
// window_latency_stats_assert.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef WINDOW_LATENCY_STATS_ASSERT_SVH
`define WINDOW_LATENCY_STATS_ASSERT_SVH

// clocked property with reset disable
`define WLS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication: antecedent |-> consequent
`define WLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `WLS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== design/wls_pkg.sv =====
// ----------------------------------------------------------------------------
// wls_pkg
// Widths, constants and divider request/response types for the
// window latency statistics block.
// ----------------------------------------------------------------------------
package wls_pkg;

    localparam int VAL_W  = 32;
    localparam int RATE_W = 10;
    localparam int FILL_W = 6;

    localparam logic [VAL_W-1:0] RATE_SCALE = VAL_W'(1000);
    localparam logic [VAL_W-1:0] ALL_ONES   = {VAL_W{1'b1}};

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/wls_if.sv =====
// ----------------------------------------------------------------------------
// wls_if
// Valid/ready stream interfaces for the input items and the result items.
// ----------------------------------------------------------------------------
interface wls_in_if
    import wls_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [VAL_W-1:0] reading_ms;

    modport source (output valid, output cmd, output reading_ms, input ready);
    modport sink   (input valid, input cmd, input reading_ms, output ready);
endinterface

interface wls_out_if
    import wls_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  average_ms;
    logic [RATE_W-1:0] rate_per_second;
    logic [VAL_W-1:0]  minimum_ms;
    logic [VAL_W-1:0]  maximum_ms;
    logic [FILL_W-1:0] fill_count;
    logic [VAL_W-1:0]  running_total;
    logic [VAL_W-1:0]  frames_seen;

    modport source (
        output valid, output average_ms, output rate_per_second, output minimum_ms,
        output maximum_ms, output fill_count, output running_total, output frames_seen,
        input ready
    );
    modport sink (
        input valid, input average_ms, input rate_per_second, input minimum_ms,
        input maximum_ms, input fill_count, input running_total, input frames_seen,
        output ready
    );
endinterface

// ===== design/wls_divider.sv =====
// ----------------------------------------------------------------------------
// wls_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wls_divider
    import wls_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(VAL_W);

    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic [VAL_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [VAL_W:0] trial;
    logic [VAL_W:0] diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[VAL_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the difference only when the subtract did not borrow, else keep the trial remainder
            if (!diff[VAL_W])
            begin
                rem_next = diff[VAL_W-1:0];
            end
            else
            begin
                rem_next = trial[VAL_W-1:0];
            end
            quo_next = {quo_reg[VAL_W-2:0], ~diff[VAL_W]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(VAL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/wls_ring.sv =====
// ----------------------------------------------------------------------------
// wls_ring
// Sample ring memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wls_ring
    import wls_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [VAL_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [VAL_W-1:0] rd_data
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/window_latency_stats.sv =====
// ----------------------------------------------------------------------------
// window_latency_stats
// Moving window average, fps, min, max and totals of millisecond latencies.
// ----------------------------------------------------------------------------
// Flow: each input beat goes through the ring read and update, sequencing, the
// average and the rate on the shared 32-step divider, then the output load.
// No new item is taken until the last one's result is loaded; a division is
// skipped for an empty window or a zero average.
// Reset: async active low; statistics clear, min goes to all ones, the ring
// holds no valid data and needs no clearing pass.
module window_latency_stats
    import wls_pkg::*;
#(
    parameter int WINDOW = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    wls_in_if.sink   sample_in,
    wls_out_if.source result_out
);

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_READ      = 3'd1;
    localparam logic [2:0] S_UPDATE    = 3'd2;
    localparam logic [2:0] S_AVG_GO    = 3'd3;
    localparam logic [2:0] S_AVG_WAIT  = 3'd4;
    localparam logic [2:0] S_RATE_GO   = 3'd5;
    localparam logic [2:0] S_RATE_WAIT = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [VAL_W-1:0]  sample_reg, sample_next;
    logic              have_reg, have_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [CW-1:0]     held_reg, held_next;
    logic [VAL_W-1:0]  sum_reg, sum_next;
    logic [VAL_W-1:0]  low_reg, low_next;
    logic [VAL_W-1:0]  high_reg, high_next;
    logic [VAL_W-1:0]  total_reg, total_next;
    logic [VAL_W-1:0]  prev_reg, prev_next;
    logic [VAL_W-1:0]  frames_reg, frames_next;
    logic [VAL_W-1:0]  avg_reg, avg_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic              out_valid_reg, out_valid_next;

    logic [VAL_W-1:0]  o_avg_reg, o_min_reg, o_max_reg, o_total_reg, o_frames_reg;
    logic [RATE_W-1:0] o_rate_reg;
    logic [FILL_W-1:0] o_fill_reg;

    logic             accept;
    logic             full;
    logic             load_out;
    logic             ring_wr;
    logic [VAL_W-1:0] ring_rd_data;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    assign sample_in.ready = (state_reg == S_IDLE);
    assign accept          = sample_in.valid && sample_in.ready;
    assign full            = (held_reg == CW'(WINDOW));
    assign load_out        = (state_reg == S_DONE) && (!out_valid_reg || result_out.ready);
    assign ring_wr         = (state_reg == S_UPDATE) && have_reg;

    wls_ring #(
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (state_reg == S_READ),
        .rd_addr (slot_reg),
        .rd_data (ring_rd_data)
    );

    always_comb
    begin
        div_req.start    = ((state_reg == S_AVG_GO) && (held_reg != '0))
                        || ((state_reg == S_RATE_GO) && (avg_reg != '0));
        div_req.dividend = (state_reg == S_RATE_GO) ? RATE_SCALE : sum_reg;
        div_req.divisor  = (state_reg == S_RATE_GO) ? avg_reg : VAL_W'(held_reg);
    end

    wls_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        sample_next = sample_reg;
        have_next   = have_reg;
        slot_next   = slot_reg;
        held_next   = held_reg;
        sum_next    = sum_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        total_next  = total_reg;
        prev_next   = prev_reg;
        frames_next = frames_reg;
        avg_next    = avg_reg;
        rate_next   = rate_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sample_in.cmd)
                    begin
                        // first stamp (or a held stamp of zero) yields no interval
                        sample_next = sample_in.reading_ms - prev_reg;
                        have_next   = (prev_reg != '0);
                        prev_next   = sample_in.reading_ms;
                        frames_next = frames_reg + VAL_W'(1);
                    end
                    else
                    begin
                        sample_next = sample_in.reading_ms;
                        have_next   = 1'b1;
                    end
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (have_reg)
                begin
                    if (full)
                    begin
                        sum_next = sum_reg - ring_rd_data + sample_reg;
                    end
                    else
                    begin
                        sum_next  = sum_reg + sample_reg;
                        held_next = held_reg + CW'(1);
                    end
                    if (slot_reg == AW'(WINDOW - 1))
                    begin
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + AW'(1);
                    end
                    if (sample_reg < low_reg)
                    begin
                        low_next = sample_reg;
                    end
                    if (sample_reg > high_reg)
                    begin
                        high_next = sample_reg;
                    end
                    total_next = total_reg + sample_reg;
                end
                state_next = S_AVG_GO;
            end
            S_AVG_GO:
            begin
                if (held_reg == '0)
                begin
                    avg_next   = '0;
                    state_next = S_RATE_GO;
                end
                else
                begin
                    state_next = S_AVG_WAIT;
                end
            end
            S_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient;
                    state_next = S_RATE_GO;
                end
            end
            S_RATE_GO:
            begin
                if (avg_reg == '0)
                begin
                    rate_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RATE_WAIT;
                end
            end
            S_RATE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    rate_next  = div_rsp.quotient[RATE_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_reg      <= 1'b0;
            slot_reg      <= '0;
            held_reg      <= '0;
            sum_reg       <= '0;
            low_reg       <= ALL_ONES;
            high_reg      <= '0;
            total_reg     <= '0;
            prev_reg      <= '0;
            frames_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_reg      <= have_next;
            slot_reg      <= slot_next;
            held_reg      <= held_next;
            sum_reg       <= sum_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            total_reg     <= total_next;
            prev_reg      <= prev_next;
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        avg_reg    <= avg_next;
        rate_reg   <= rate_next;
        if (load_out)
        begin
            o_avg_reg    <= avg_reg;
            o_rate_reg   <= rate_reg;
            o_min_reg    <= low_reg;
            o_max_reg    <= high_reg;
            o_fill_reg   <= FILL_W'(held_reg);
            o_total_reg  <= total_reg;
            o_frames_reg <= frames_reg;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.average_ms      = o_avg_reg;
    assign result_out.rate_per_second = o_rate_reg;
    assign result_out.minimum_ms      = o_min_reg;
    assign result_out.maximum_ms      = o_max_reg;
    assign result_out.fill_count      = o_fill_reg;
    assign result_out.running_total   = o_total_reg;
    assign result_out.frames_seen     = o_frames_reg;

endmodule

// ===== design/wls_checker.sv =====
// ----------------------------------------------------------------------------
// wls_checker
// Port-level assertions for window_latency_stats, bound to the top level.
// ----------------------------------------------------------------------------
`include "window_latency_stats_assert.svh"

module wls_checker
    import wls_pkg::*;
#(
    parameter int WINDOW = 32
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [VAL_W-1:0]  average_ms,
    input logic [RATE_W-1:0] rate_per_second,
    input logic [VAL_W-1:0]  minimum_ms,
    input logic [VAL_W-1:0]  maximum_ms,
    input logic [FILL_W-1:0] fill_count
);

    // a result beat is held until taken
    `WLS_ASSERT_IMP(a_out_hold, clk, rst_n, out_valid && !out_ready, ##1 out_valid,
        "result dropped before it was taken")

    // an accepted item keeps the block busy for the next cycle
    `WLS_ASSERT_IMP(a_busy_after_accept, clk, rst_n, in_valid && in_ready, ##1 !in_ready,
        "input ready right after an accepted beat")

    `WLS_ASSERT_IMP(a_rate_zero, clk, rst_n, out_valid && (average_ms == '0),
        rate_per_second == '0, "nonzero rate with zero average")

    `WLS_ASSERT_IMP(a_fill_range, clk, rst_n, out_valid,
        fill_count <= FILL_W'(WINDOW), "fill count beyond window")

    `WLS_ASSERT_IMP(a_min_le_max, clk, rst_n, out_valid && (fill_count != '0),
        minimum_ms <= maximum_ms, "minimum above maximum with samples held")

endmodule

bind window_latency_stats wls_checker #(
    .WINDOW (WINDOW)
) u_wls_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (sample_in.valid),
    .in_ready        (sample_in.ready),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .average_ms      (result_out.average_ms),
    .rate_per_second (result_out.rate_per_second),
    .minimum_ms      (result_out.minimum_ms),
    .maximum_ms      (result_out.maximum_ms),
    .fill_count      (result_out.fill_count)
);

// ===== tb/sv/window_latency_stats_test.sv =====
// ----------------------------------------------------------------------------
// window_latency_stats_test
// Self-checking bench for the moving window latency statistics block. A
// queue of sample and timestamp beats feeds a clocked driver. A clocked
// monitor folds every accepted input beat into a local model of the window
// and compares each result beat, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
module window_latency_stats_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wls_pkg::*;

    localparam int RING_DEPTH     = 32;
    localparam int SLOT_W         = $clog2(RING_DEPTH);
    localparam int LATENCY_CYCLES = 72;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int RANDOM_ITEMS   = 700;
    localparam int PRINT_CAP      = 50;

    typedef enum logic { CMD_SAMPLE = 1'b0, CMD_STAMP = 1'b1 } item_kind_e;

    typedef struct {
        item_kind_e       kind;
        logic [VAL_W-1:0] value;
        bit               drain;   // hold this beat until every result is back
    } latency_item_t;

    typedef struct packed {
        logic [VAL_W-1:0]  average_ms;
        logic [RATE_W-1:0] rate_per_second;
        logic [VAL_W-1:0]  minimum_ms;
        logic [VAL_W-1:0]  maximum_ms;
        logic [FILL_W-1:0] fill_count;
        logic [VAL_W-1:0]  running_total;
        logic [VAL_W-1:0]  frames_seen;
    } window_stats_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wls_in_if  in_bus ();
    wls_out_if out_bus ();

    window_latency_stats #(.WINDOW(RING_DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (in_bus),
        .result_out (out_bus)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Bench-side drive registers
    // ------------------------------------------------------------------
    logic             drive_valid = 1'b0;
    logic             drive_cmd   = 1'b0;
    logic [VAL_W-1:0] drive_value = '0;
    logic             take_ready  = 1'b0;

    assign in_bus.valid      = drive_valid;
    assign in_bus.cmd        = drive_cmd;
    assign in_bus.reading_ms = drive_value;
    assign out_bus.ready     = take_ready;

    latency_item_t latency_items [$];
    window_stats_t expected_stats [$];
    int            items_total;
    int            items_taken;
    int            results_seen;
    int            mismatch_count;

    // ------------------------------------------------------------------
    // Window model
    // ------------------------------------------------------------------
    logic [VAL_W-1:0]  sample_ring [RING_DEPTH];
    logic [SLOT_W-1:0] ring_slot    = '0;
    logic [FILL_W-1:0] ring_fill    = '0;
    logic [VAL_W-1:0]  ring_sum     = '0;
    logic [VAL_W-1:0]  low_water    = ALL_ONES;
    logic [VAL_W-1:0]  high_water   = '0;
    logic [VAL_W-1:0]  sample_total = '0;
    logic [VAL_W-1:0]  last_stamp   = '0;
    logic [VAL_W-1:0]  stamp_tally  = '0;

    task automatic push_latency(input logic [VAL_W-1:0] v);
        if (ring_fill == FILL_W'(RING_DEPTH))
            ring_sum = ring_sum - sample_ring[ring_slot];
        else
            ring_fill = ring_fill + 1'b1;
        sample_ring[ring_slot] = v;
        ring_sum  = ring_sum + v;
        ring_slot = ring_slot + 1'b1;   // depth is a power of two
        if (v < low_water)
            low_water = v;
        if (v > high_water)
            high_water = v;
        sample_total = sample_total + v;
    endtask

    task automatic fold_latency_item(input item_kind_e kind, input logic [VAL_W-1:0] v,
                                     output window_stats_t r);
        logic [VAL_W-1:0] avg;
        if (kind == CMD_STAMP)
        begin
            // a zero stamp looks like no stamp at all
            if (last_stamp != '0)
                push_latency(v - last_stamp);
            last_stamp  = v;
            stamp_tally = stamp_tally + 1'b1;
        end
        else
        begin
            push_latency(v);
        end
        avg = (ring_fill != '0) ? ring_sum / VAL_W'(ring_fill) : '0;
        r.average_ms      = avg;
        r.rate_per_second = (avg != '0) ? RATE_W'(RATE_SCALE / avg) : '0;
        r.minimum_ms      = low_water;
        r.maximum_ms      = high_water;
        r.fill_count      = ring_fill;
        r.running_total   = sample_total;
        r.frames_seen     = stamp_tally;
    endtask

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] result %0d %s: got %h want %h",
                     $realtime, results_seen, what, got, want);
    endtask

    task automatic check_stats(input window_stats_t got, input window_stats_t want);
        if (got.average_ms !== want.average_ms)
            report_mismatch("average_ms", got.average_ms, want.average_ms);
        if (got.rate_per_second !== want.rate_per_second)
            report_mismatch("rate_per_second", VAL_W'(got.rate_per_second),
                            VAL_W'(want.rate_per_second));
        if (got.minimum_ms !== want.minimum_ms)
            report_mismatch("minimum_ms", got.minimum_ms, want.minimum_ms);
        if (got.maximum_ms !== want.maximum_ms)
            report_mismatch("maximum_ms", got.maximum_ms, want.maximum_ms);
        if (got.fill_count !== want.fill_count)
            report_mismatch("fill_count", VAL_W'(got.fill_count), VAL_W'(want.fill_count));
        if (got.running_total !== want.running_total)
            report_mismatch("running_total", got.running_total, want.running_total);
        if (got.frames_seen !== want.frames_seen)
            report_mismatch("frames_seen", got.frames_seen, want.frames_seen);
    endtask

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    int  hold_left;
    bit  hold_drawn;
    bit  sender_calm;

    always @(posedge clk or negedge rst_n)
    begin
        latency_item_t nxt;
        if (!rst_n)
        begin
            drive_valid <= 1'b0;
            drive_cmd   <= 1'b0;
            drive_value <= '0;
            hold_left   = 0;
            hold_drawn  = 1'b0;
        end
        else if (!drive_valid || in_bus.ready)
        begin
            if (!hold_drawn)
            begin
                hold_left  = sender_calm ? 0 : $urandom_range(0, 10);
                hold_drawn = 1'b1;
                if ($urandom_range(0, 29) == 0)
                    sender_calm = !sender_calm;
            end
            // a drain beat also waits out the beat accepted at this edge
            if (latency_items.size() == 0 ||
                (latency_items[0].drain && (expected_stats.size() != 0 || drive_valid)))
            begin
                drive_valid <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                drive_valid <= 1'b0;
            end
            else
            begin
                nxt = latency_items.pop_front();
                drive_valid <= 1'b1;
                drive_cmd   <= nxt.kind;
                drive_value <= nxt.value;
                hold_drawn  = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: fold input beats, check result beats, stall the receiver
    // ------------------------------------------------------------------
    int  stall_left;
    bit  receiver_calm;

    always @(posedge clk or negedge rst_n)
    begin
        window_stats_t want;
        window_stats_t got;
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (in_bus.valid && in_bus.ready)
            begin
                fold_latency_item(item_kind_e'(in_bus.cmd), in_bus.reading_ms, want);
                expected_stats.push_back(want);
                items_taken++;
            end
            if (out_bus.valid && take_ready)
            begin
                got.average_ms      = out_bus.average_ms;
                got.rate_per_second = out_bus.rate_per_second;
                got.minimum_ms      = out_bus.minimum_ms;
                got.maximum_ms      = out_bus.maximum_ms;
                got.fill_count      = out_bus.fill_count;
                got.running_total   = out_bus.running_total;
                got.frames_seen     = out_bus.frames_seen;
                if (expected_stats.size() == 0)
                    report_mismatch("unexpected result", '0, '0);
                else
                    check_stats(got, expected_stats.pop_front());
                results_seen++;
                stall_left = receiver_calm ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 19) == 0)
                    receiver_calm = !receiver_calm;
                take_ready <= (stall_left == 0);
            end
            else if (out_bus.valid)
            begin
                if (stall_left > 0)
                    stall_left--;
                if (stall_left == 0)
                    take_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("window_latency_stats_test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    task automatic add_item(input item_kind_e kind, input logic [VAL_W-1:0] v,
                            input bit drain = 1'b0);
        latency_item_t it;
        it.kind  = kind;
        it.value = v;
        it.drain = drain;
        latency_items.push_back(it);
    endtask

    initial
    begin
        int               seg_kind;
        int               seg_len;
        int               n_random;
        int               waited;
        logic [VAL_W-1:0] stamp_cursor;
        logic [VAL_W-1:0] v;
        bit               drain;

        // directed: empty window, zero stamp, stamp wrap, field extremes
        add_item(CMD_STAMP,  32'd1000);            // first stamp: no sample yet
        add_item(CMD_STAMP,  32'd1016);
        add_item(CMD_STAMP,  32'd0);               // backwards: wraps, then zero held
        add_item(CMD_STAMP,  32'd500);             // previous stamp is zero: no sample
        add_item(CMD_STAMP,  32'hFFFF_FFF0);
        add_item(CMD_STAMP,  32'h0000_000A);       // interval across the 32-bit wrap
        add_item(CMD_SAMPLE, ALL_ONES, 1'b1);      // window sum wraps
        add_item(CMD_SAMPLE, 32'd0);
        add_item(CMD_SAMPLE, 32'd1);
        add_item(CMD_SAMPLE, 32'd1000);
        add_item(CMD_STAMP,  ALL_ONES);
        add_item(CMD_STAMP,  ALL_ONES);            // zero interval
        add_item(CMD_SAMPLE, 32'h8000_0000);
        add_item(CMD_SAMPLE, 32'h7FFF_FFFF, 1'b1);

        // random: segments of one flavor each
        n_random     = 0;
        stamp_cursor = $urandom;
        while (n_random < RANDOM_ITEMS)
        begin
            seg_kind = $urandom_range(0, 5);
            seg_len  = $urandom_range(10, 60);
            if (seg_kind == 3)
                stamp_cursor = ($urandom_range(0, 2) == 0) ?
                               32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
            repeat (seg_len)
            begin
                drain = ($urandom_range(0, 11) == 0);
                case (seg_kind)
                    0: add_item(CMD_SAMPLE, $urandom_range(0, 3), drain);
                    1: add_item(CMD_SAMPLE, $urandom_range(1, 2000), drain);
                    2: add_item(CMD_SAMPLE, $urandom, drain);
                    3:
                    begin
                        // steady frame stream, now and then a repeated stamp
                        if ($urandom_range(0, 19) != 0)
                            stamp_cursor = stamp_cursor + $urandom_range(1, 100);
                        add_item(CMD_STAMP, stamp_cursor, drain);
                    end
                    4: add_item(item_kind_e'($urandom_range(0, 1)), $urandom, drain);
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0:       v = '0;
                            1:       v = ALL_ONES;
                            2:       v = $urandom_range(0, 50);
                            default: v = $urandom;
                        endcase
                        add_item(CMD_STAMP, v, drain);
                    end
                endcase
                n_random++;
            end
        end
        items_total = latency_items.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken < items_total)
            @(posedge clk);
        waited = 0;
        while (expected_stats.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY_CYCLES + 16) @(posedge clk);
        while (expected_stats.size() != 0)
        begin
            report_mismatch("missing result", '0, '0);
            void'(expected_stats.pop_front());
        end

        if (mismatch_count == 0)
            $display("window_latency_stats_test passed");
        else
            $display("window_latency_stats_test failed");
        $finish;
    end

endmodule
